FILE: src/akar_pkg.sv
// shared types and constants for the accelerating key autorepeat block
`default_nettype none

package akar_pkg;

    localparam int KEY_W      = 4;   // key_levels_n width
    localparam int FIRE_W     = 4;   // fire_mask width
    localparam int TDATA_W    = 8;   // stream words padded to whole bytes
    localparam int DLY_W      = 5;   // counter and delay width
    localparam int PCT_W      = 7;   // decay percent width
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 4096
    localparam int DIV100_SHIFT = 19;
    localparam int MAGIC_W      = 13;
    localparam int MULT_W       = 20;   // decay_percent * magic
    localparam int PROD_W       = DLY_W + MULT_W;
    localparam int QUOT_W       = PROD_W - DIV100_SHIFT;

    localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 13'd5243;

    localparam logic [DLY_W-1:0] RESET_START_DELAY   = 5'd25;
    localparam logic [PCT_W-1:0] RESET_DECAY_PERCENT = 7'd85;
    localparam logic [DLY_W-1:0] DELAY_MAX           = 5'd31;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERCENT = 1'b1;

    // live configuration as seen by every lane
    typedef struct packed {
        logic [DLY_W-1:0]  start_delay;
        logic [MULT_W-1:0] decay_mult;   // decay_percent pre-scaled by the magic
    } cfg_t;

    function automatic logic [MULT_W-1:0] scale_percent(input logic [PCT_W-1:0] pct);
        logic [MULT_W-1:0] p;
        p = MULT_W'(pct) * MULT_W'(DIV100_MAGIC);
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: src/akar_lane.sv
// one key lane: tick counter, repeat delay and pressed flag
`default_nettype none

module akar_lane (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,      // poll word accepted this cycle
    input  wire logic          pressed,
    input  wire akar_pkg::cfg_t cfg,
    output logic               fire
);
    import akar_pkg::*;

    logic [DLY_W-1:0]  count_reg, count_next, count_clr;
    logic [DLY_W-1:0]  delay_reg, delay_next, delay_dec;
    logic              was_reg;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    assign fire = pressed && (count_reg >= delay_reg);

    // floor(delay * pct / 100), saturated to the 5-bit maximum
    assign prod      = PROD_W'(delay_reg) * PROD_W'(cfg.decay_mult);
    assign quot      = prod[PROD_W-1:DIV100_SHIFT];
    assign delay_dec = (quot > QUOT_W'(DELAY_MAX)) ? DELAY_MAX : quot[DLY_W-1:0];

    always_comb
    begin
        count_clr  = fire ? '0 : count_reg;
        delay_next = delay_reg;
        if (fire)
        begin
            delay_next = was_reg ? delay_dec : cfg.start_delay;
        end
        count_next = (count_clr < cfg.start_delay) ? count_clr + 1'b1 : count_clr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            delay_reg <= RESET_START_DELAY;
            was_reg   <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            delay_reg <= delay_next;
            was_reg   <= pressed;
        end
    end

endmodule

`default_nettype wire

FILE: src/akar_merge.sv
// gathers lane fire bits into the result word, output register plus skid slot
`default_nettype none

module akar_merge #(
    parameter int NUM_KEYS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [NUM_KEYS-1:0]           fire,
    output logic                               can_push,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [akar_pkg::FIRE_W-1:0]        out_mask
);
    import akar_pkg::*;

    logic [FIRE_W-1:0] mask;
    logic [FIRE_W-1:0] out_reg;
    logic [FIRE_W-1:0] skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              pop;

    // keys past the result width are dropped, missing keys read as no fire
    for (genvar i = 0; i < FIRE_W; i++)
    begin : g_mask
        if (i < NUM_KEYS)
        begin : g_key
            assign mask[i] = fire[i];
        end
        else
        begin : g_none
            assign mask[i] = 1'b0;
        end
    end

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_mask  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= mask;
            end
            else
            begin
                skid_reg <= mask;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/accelerating_key_autorepeat_core.sv
// top level of the accelerating key autorepeat block
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------
// s_axis  | in        | s_tvalid / s_tready  | s_tdata[3:0] key_levels_n
// m_axis  | out       | m_tvalid / m_tready  | m_tdata[3:0] fire_mask
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one poll word per cycle while s_tready is high; each lane updates its key at the
// accept edge, where the fire mask is registered into the output register or skid slot
// an extra skid slot keeps input flowing for one word while the output stalls;
// s_tready drops only when both output slots are full
// cfg writes are always ready and take effect on the next poll word
// reset restores start delay 25, decay 85 percent, counters zero, keys released
`default_nettype none

module accelerating_key_autorepeat_core #(
    parameter int NUM_KEYS = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // poll words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [akar_pkg::TDATA_W-1:0]     s_tdata,   // [3:0] key_levels_n
    // fire words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [akar_pkg::TDATA_W-1:0]          m_tdata,   // [3:0] fire_mask
    // register writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [akar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [akar_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import akar_pkg::*;

    cfg_t                 cfg_reg;
    logic                 step;
    logic                 can_push;
    logic [NUM_KEYS-1:0]  pressed;
    logic [NUM_KEYS-1:0]  fire;
    logic [FIRE_W-1:0]    fire_mask;
    logic [KEY_W-1:0]     key_levels_n;

    assign key_levels_n = s_tdata[KEY_W-1:0];
    assign s_tready     = can_push;
    assign step         = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;
    assign m_tdata      = TDATA_W'(fire_mask);

    // register file; decay percent is stored pre-multiplied by the 1/100 magic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay <= RESET_START_DELAY;
            cfg_reg.decay_mult  <= scale_percent(RESET_DECAY_PERCENT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_DELAY:   cfg_reg.start_delay <= cfg_data[DLY_W-1:0];
                REG_DECAY_PERCENT: cfg_reg.decay_mult  <= scale_percent(cfg_data[PCT_W-1:0]);
            endcase
        end
    end

    // one lane per key; keys past the input width see a low pin, i.e. pressed
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        if (i < KEY_W)
        begin : g_pin
            assign pressed[i] = ~key_levels_n[i];
        end
        else
        begin : g_nopin
            assign pressed[i] = 1'b1;
        end

        akar_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (step),
            .pressed (pressed[i]),
            .cfg     (cfg_reg),
            .fire    (fire[i])
        );
    end

    // fire bits merge into the result word and wait in the output slots
    akar_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .fire      (fire),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mask  (fire_mask)
    );

endmodule

`default_nettype wire

FILE: src/akar_checker.sv
// port-level checks for the accelerating key autorepeat block, with bind
`default_nettype none

module akar_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [akar_pkg::TDATA_W-1:0]     m_tdata
);
    import akar_pkg::*;

    // input stalls only when an output word is already waiting
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no output word pending");

    // a word taken into an empty output shows up on the next cycle
    a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
        else $error("accepted poll word did not reach the output");

    // a word taken while the output stalls fills the skid slot
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tvalid && !m_tready) |=> !s_tready)
        else $error("skid slot not filled under output stall");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed while stalled");

    // padding bits above the fire mask stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[TDATA_W-1:FIRE_W] == '0))
        else $error("output padding bits not zero");

endmodule

bind accelerating_key_autorepeat_core akar_checker u_akar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/accelerating_key_autorepeat_core_test.sv
// self-checking bench for the accelerating key autorepeat core
`default_nettype none

module accelerating_key_autorepeat_core_test;
    import akar_pkg::*;

    localparam int NKEYS    = 4;
    localparam int LIMIT    = 1000000;   // cycles before the run is declared hung
    localparam int HOLD_OFF = 300;       // long output stall, fills the block up

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;     // [3:0] key_levels_n
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // [3:0] fire_mask
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_START_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    accelerating_key_autorepeat_core #(
        .NUM_KEYS (NKEYS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the key lanes and the live settings
    // ------------------------------------------------------------------
    logic [DLY_W-1:0] key_ticks  [NKEYS];
    logic [DLY_W-1:0] key_delay  [NKEYS];
    logic             key_held   [NKEYS];
    logic [DLY_W-1:0] shadow_start;
    logic [PCT_W-1:0] shadow_pct;

    logic [KEY_W-1:0]  poll_q[$];       // poll words waiting to be offered
    logic [FIRE_W-1:0] fire_exp_q[$];   // fire masks still owed by the block

    int  errors      = 0;
    int  polls_taken = 0;
    int  fires_seen  = 0;
    int  reg_writes  = 0;
    int  cycles      = 0;
    bit  poll_taken  = 1'b0;   // poll word accepted at the last rising edge
    bit  idle_on     = 1'b0;   // random gaps and stalls enabled
    int  send_gap    = 0;
    int  stall_left  = 0;
    int  hold_reqs   = 0;      // bumped by the sequence to ask for a long stall
    int  hold_seen   = 0;

    // one poll tick through every lane, returns the keys that fire
    function automatic logic [FIRE_W-1:0] predict_fire(input logic [KEY_W-1:0] levels_n);
        logic [FIRE_W-1:0] mask;
        logic              pressed;
        logic [11:0]       prod;
        mask = '0;
        for (int k = 0; k < NKEYS; k++)
        begin
            // lanes past the input width see a low pin, so they read pressed
            pressed = (k < KEY_W) ? !levels_n[k] : 1'b1;
            if (pressed && key_ticks[k] >= key_delay[k])
            begin
                key_ticks[k] = '0;
                if (!key_held[k])
                    key_delay[k] = shadow_start;
                else
                begin
                    // held repeat shrinks the delay; above 100 percent it grows and clips
                    prod = 12'(key_delay[k]) * 12'(shadow_pct);
                    prod = prod / 12'd100;
                    key_delay[k] = (prod > 12'(DELAY_MAX)) ? DELAY_MAX : prod[DLY_W-1:0];
                end
                if (k < FIRE_W)
                    mask[k] = 1'b1;
            end
            key_held[k] = pressed;
            // counter parks at the start delay, or above it if that was lowered
            if (key_ticks[k] < shadow_start)
                key_ticks[k] = key_ticks[k] + 1'b1;
        end
        return mask;
    endfunction

    // mostly short idle stretches, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // monitor: everything sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic [FIRE_W-1:0] want;
        poll_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (m_tdata[FIRE_W-1:0] != '0)
                    fires_seen++;
                if (fire_exp_q.size() == 0)
                begin
                    $error("fire word with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = fire_exp_q.pop_front();
                    if (m_tdata[FIRE_W-1:0] !== want)
                    begin
                        $error("fire_mask: expected %h, got %h", want, m_tdata[FIRE_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[TDATA_W-1:FIRE_W] !== '0)
                    begin
                        $error("tdata padding: expected %h, got %h", 0,
                               m_tdata[TDATA_W-1:FIRE_W]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                poll_taken = 1'b1;
                polls_taken++;
                fire_exp_q.push_back(predict_fire(s_tdata[KEY_W-1:0]));
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index == REG_START_DELAY)
                    shadow_start = cfg_data[DLY_W-1:0];
                else if (cfg_index == REG_DECAY_PERCENT)
                    shadow_pct = cfg_data[PCT_W-1:0];
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // poll driver: holds each word until taken, random gaps in between
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (poll_taken)
        begin
            void'(poll_q.pop_front());
            send_gap = idle_on ? gap_len() : 0;
        end
        if (send_gap > 0)
        begin
            send_gap--;
            s_tvalid <= 1'b0;
        end
        else if (poll_q.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= TDATA_W'(poll_q[0]);
        end
        else
            s_tvalid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // fire receiver: random stalls when idling, plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen  = hold_reqs;
            stall_left = HOLD_OFF;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 2) == 0)
        begin
            stall_left = gap_len();
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int start_v, input int pct_v);
        write_reg(REG_START_DELAY, start_v);
        write_reg(REG_DECAY_PERCENT, pct_v);
    endtask

    // mostly held key patterns, some long enough to reach the fast repeats,
    // the rest short bursts of chatter
    task automatic fill_random(input int n);
        int               left;
        int               len;
        logic [KEY_W-1:0] pat;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pat = KEY_W'($urandom_range(0, 15));
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(2, 30);
                if (len > left)
                    len = left;
                repeat (len) poll_q.push_back(pat);
            end
            else
            begin
                len = $urandom_range(1, 5);
                if (len > left)
                    len = left;
                repeat (len) poll_q.push_back(KEY_W'($urandom_range(0, 15)));
            end
            left -= len;
        end
    endtask

    // wait until every word went in and every fire word came out
    task automatic drain();
        do
            @(posedge clk);
        while (poll_q.size() != 0 || s_tvalid || fire_exp_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        shadow_start = RESET_START_DELAY;
        shadow_pct   = RESET_DECAY_PERCENT;
        for (int k = 0; k < NKEYS; k++)
        begin
            key_ticks[k] = '0;
            key_delay[k] = RESET_START_DELAY;
            key_held[k]  = 1'b0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: all released, all pressed, halves, each key alone
        idle_on = 1'b0;
        foreach (poll_q[i]) ;
        poll_q.push_back(4'hF);
        poll_q.push_back(4'h0);
        poll_q.push_back(4'h5);
        poll_q.push_back(4'hA);
        poll_q.push_back(4'hE);
        poll_q.push_back(4'hD);
        poll_q.push_back(4'hB);
        poll_q.push_back(4'h7);
        poll_q.push_back(4'h0);
        poll_q.push_back(4'hF);
        drain();

        // long receiver hold-off while the sender keeps offering
        idle_on = 1'b1;
        fill_random(150);
        hold_reqs++;
        drain();

        // start delay zero: a pressed key fires on every tick once its delay is zero
        set_regs(0, 100);
        idle_on = 1'b0;
        repeat (4) poll_q.push_back(4'h0);
        poll_q.push_back(4'hF);
        repeat (3) poll_q.push_back(4'hE);
        fill_random(120);
        drain();

        // largest start delay and decay above one hundred, delay clips at max
        set_regs(31, 127);
        idle_on = 1'b1;
        fill_random(150);
        drain();

        // start lowered under parked counters, decay to zero at once
        set_regs(1, 0);
        idle_on = 1'b0;
        poll_q.push_back(4'h0);
        poll_q.push_back(4'h0);
        poll_q.push_back(4'h0);
        fill_random(120);
        drain();

        set_regs(5, 101);
        idle_on = 1'b1;
        fill_random(120);
        drain();

        // random settings, alternating stretches with and without idling
        for (int p = 0; p < 6; p++)
        begin
            set_regs($urandom_range(0, 31), $urandom_range(0, 127));
            idle_on = p[0];
            fill_random(120);
            drain();
        end

        if (fire_exp_q.size() != 0)
        begin
            $error("fire words never delivered: %0d", fire_exp_q.size());
            errors++;
        end
        $display("covered %0d poll words, %0d fire words with a key firing, %0d register writes",
                 polls_taken, fires_seen, reg_writes);
        $display("settings spanned start delay 0 to 31 and decay 0 to 127 percent");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
